>>> rtl/dwqpc_pkg.sv
package dwqpc_pkg;

  // Full-scale drive value and the setpoint loaded at reset.
  localparam int unsigned PWM_FULL     = 254;
  localparam int unsigned START_TARGET = 100;

  // Field widths.
  localparam int unsigned PWR_W = 8;   // power field
  localparam int unsigned DIV_W = 16;  // gain divisor
  localparam int unsigned OFF_W = 16;  // turn offset
  localparam int unsigned RMP_W = 8;   // ramp step
  localparam int unsigned CFG_AW = 3;  // config register index
  localparam int unsigned CFG_DW = 16; // config write data

  // Error datapath: wide enough for any count width up to 64 plus headroom.
  localparam int unsigned ERR_W = 66;
  localparam int unsigned SAT_W = 64;

  // Divider: quotient bits and dividend width (mag * PWM_FULL).
  localparam int unsigned QUO_W = $clog2(PWM_FULL + 1);
  localparam int unsigned DVD_W = DIV_W + QUO_W;
  localparam int unsigned STEP_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;
  localparam logic [QUO_W-1:0] PWM_FULL_Q = QUO_W'(PWM_FULL);

  // Config register indexes.
  localparam logic [CFG_AW-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DIVISOR  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_RAMP     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_OFFSET   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_L_INVERT = 3'd4;
  localparam logic [CFG_AW-1:0] REG_R_INVERT = 3'd5;

  // Next pattern in the forward direction: 0 -> 1 -> 3 -> 2 -> 0.
  function automatic logic [1:0] quad_next(input logic [1:0] pat);
    logic [1:0] nxt;
    case (pat)
      2'd0:    nxt = 2'd1;
      2'd1:    nxt = 2'd3;
      2'd3:    nxt = 2'd2;
      default: nxt = 2'd0;
    endcase
    return nxt;
  endfunction

  // Count step for one wheel: +1, -1 or hold; double steps hold.
  function automatic logic [1:0] quad_step(input logic [1:0] prev, input logic [1:0] now);
    logic [1:0] stp;
    stp = 2'b00;
    if (quad_next(prev) == now) begin
      stp = 2'b01;
    end else if (quad_next(now) == prev) begin
      stp = 2'b11;
    end
    return stp;
  endfunction

endpackage

>>> rtl/dual_wheel_quadrature_p_control.sv
// A word without an enabled tick is absorbed without leaving idle and gives no result;
// an enabled tick runs one shared error datapath once per wheel, left then right, each
// followed by an 8-step divider, then hands its result word to the output register.
// No new tick word is taken until that result is handed on, which can wait on m_axis_tready.
// Reset (rst_ni low, async): counts and pin history cleared, setpoint = START_TARGET,
// config registers at their defaults, no result pending.
module dual_wheel_quadrature_p_control #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] left_a, [1] left_b, [2] right_a, [3] right_b
  input  logic        s_axis_tuser,   // [0] tick
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] left_forward, [8:1] left_power,
                                      // [9] right_forward, [17:10] right_power
  // Config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [dwqpc_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [dwqpc_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned EW = dwqpc_pkg::ERR_W;
  localparam int unsigned QW = dwqpc_pkg::QUO_W;
  localparam int unsigned DW = dwqpc_pkg::DIV_W;
  localparam int unsigned PW = dwqpc_pkg::PWR_W;
  localparam int unsigned NW = dwqpc_pkg::DVD_W;
  localparam int unsigned SW = dwqpc_pkg::STEP_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TGT  = 3'd1; // clamp(target -/+ offset)
  localparam logic [2:0] ST_ERR  = 3'd2; // subtract wheel count
  localparam logic [2:0] ST_MAG  = 3'd3; // |error|, saturation test, scale
  localparam logic [2:0] ST_DIV  = 3'd4; // one quotient bit per cycle
  localparam logic [2:0] ST_OUT  = 3'd5; // hand result to output register

  // ---------------------------------------------------------------------------
  // Config registers (always ready; the host writes only while idle)
  // ---------------------------------------------------------------------------
  logic                enable_q;
  logic [DW-1:0]       divisor_q;
  logic [dwqpc_pkg::RMP_W-1:0] ramp_q;
  logic [dwqpc_pkg::OFF_W-1:0] offset_q;
  logic                l_inv_q, r_inv_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      divisor_q <= DW'(40);
      ramp_q    <= dwqpc_pkg::RMP_W'(5);
      offset_q  <= '0;
      l_inv_q   <= 1'b1;
      r_inv_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        dwqpc_pkg::REG_ENABLE:   enable_q  <= cfg_data_i[0];
        dwqpc_pkg::REG_DIVISOR:  divisor_q <= cfg_data_i[DW-1:0];
        dwqpc_pkg::REG_RAMP:     ramp_q    <= cfg_data_i[dwqpc_pkg::RMP_W-1:0];
        dwqpc_pkg::REG_OFFSET:   offset_q  <= cfg_data_i[dwqpc_pkg::OFF_W-1:0];
        dwqpc_pkg::REG_L_INVERT: l_inv_q   <= cfg_data_i[0];
        dwqpc_pkg::REG_R_INVERT: r_inv_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Quadrature decode, done in the accept cycle
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] l_pos_q, r_pos_q, tgt_q;
  logic [1:0]            l_pat_q, r_pat_q;
  logic [1:0]            l_pat, r_pat, l_stp, r_stp;
  logic                  in_acc, run_tick;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign run_tick = s_axis_tuser & enable_q;

  assign l_pat = s_axis_tdata[1:0] ^ {2{l_inv_q}};
  assign r_pat = s_axis_tdata[3:2] ^ {2{r_inv_q}};
  assign l_stp = dwqpc_pkg::quad_step(l_pat_q, l_pat);
  assign r_stp = dwqpc_pkg::quad_step(r_pat_q, r_pat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_pos_q <= '0;
      r_pos_q <= '0;
      l_pat_q <= '0;
      r_pat_q <= '0;
      tgt_q   <= COUNT_BITS'(dwqpc_pkg::START_TARGET);
    end else if (in_acc) begin
      l_pat_q <= l_pat;
      r_pat_q <= r_pat;
      l_pos_q <= l_pos_q + {{(COUNT_BITS-1){l_stp[1]}}, l_stp[0]};
      r_pos_q <= r_pos_q + {{(COUNT_BITS-1){r_stp[1]}}, r_stp[0]};
      if (run_tick) begin
        tgt_q <= tgt_q + COUNT_BITS'(ramp_q);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: left wheel, then right wheel, through one shared datapath
  // ---------------------------------------------------------------------------
  logic [2:0]    state_q, state_d;
  logic          wheel_q, wheel_d;      // 0 left, 1 right
  logic [SW-1:0] step_q, step_d;

  logic [dwqpc_pkg::SAT_W-1:0] acc_q, acc_d;  // clamped target -/+ offset
  logic [EW-1:0] err_q, err_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] lo_q, lo_d;            // dividend low bits, quotient shifts in
  logic          full_q, full_d;
  logic          l_fwd_q, l_fwd_d, r_fwd_q, r_fwd_d;
  logic [PW-1:0] l_pwr_q, l_pwr_d, r_pwr_q, r_pwr_d;

  logic          out_vld_q, out_vld_d;
  logic [23:0]   out_q, out_d;

  // Shared datapath signals
  logic [EW-1:0] tgt_x, off_x, cnt_x, sum_x, mag_x;
  logic [NW-1:0] prod;
  logic [DW:0]   trial, trial_sub;
  logic          ge, big;
  logic [PW-1:0] pwr_now;

  assign tgt_x = {{(EW-COUNT_BITS){tgt_q[COUNT_BITS-1]}}, tgt_q};
  assign off_x = {{(EW-dwqpc_pkg::OFF_W){offset_q[dwqpc_pkg::OFF_W-1]}}, offset_q};
  assign cnt_x = wheel_q ? {{(EW-COUNT_BITS){r_pos_q[COUNT_BITS-1]}}, r_pos_q}
                         : {{(EW-COUNT_BITS){l_pos_q[COUNT_BITS-1]}}, l_pos_q};
  assign sum_x = wheel_q ? (tgt_x + off_x) : (tgt_x - off_x);

  assign mag_x = err_q[EW-1] ? (~err_q + EW'(1)) : err_q;
  assign big   = (divisor_q == '0) ? (mag_x != '0)
                                   : (mag_x >= {{(EW-DW){1'b0}}, divisor_q});
  assign prod  = {{QW{1'b0}}, mag_x[DW-1:0]} * {{DW{1'b0}}, dwqpc_pkg::PWM_FULL_Q};

  assign trial     = {rem_q, lo_q[QW-1]};
  assign trial_sub = trial - {1'b0, divisor_q};
  assign ge        = trial >= {1'b0, divisor_q};

  always_comb begin
    state_d   = state_q;
    wheel_d   = wheel_q;
    step_d    = step_q;
    acc_d     = acc_q;
    err_d     = err_q;
    rem_d     = rem_q;
    lo_d      = lo_q;
    full_d    = full_q;
    l_fwd_d   = l_fwd_q;
    r_fwd_d   = r_fwd_q;
    l_pwr_d   = l_pwr_q;
    r_pwr_d   = r_pwr_q;
    out_vld_d = out_vld_q & ~m_axis_tready;
    out_d     = out_q;
    pwr_now   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && run_tick) begin
          wheel_d = 1'b0;
          state_d = ST_TGT;
        end
      end
      ST_TGT: begin
        // clamp to the signed 64-bit range
        if (sum_x[EW-1:dwqpc_pkg::SAT_W-1] == '0 || sum_x[EW-1:dwqpc_pkg::SAT_W-1] == '1) begin
          acc_d = sum_x[dwqpc_pkg::SAT_W-1:0];
        end else if (sum_x[EW-1]) begin
          acc_d = {1'b1, {(dwqpc_pkg::SAT_W-1){1'b0}}};
        end else begin
          acc_d = {1'b0, {(dwqpc_pkg::SAT_W-1){1'b1}}};
        end
        state_d = ST_ERR;
      end
      ST_ERR: begin
        err_d = {{(EW-dwqpc_pkg::SAT_W){acc_q[dwqpc_pkg::SAT_W-1]}}, acc_q} - cnt_x;
        state_d = ST_MAG;
      end
      ST_MAG: begin
        if (wheel_q) begin
          r_fwd_d = ~err_q[EW-1] & (err_q != '0);
        end else begin
          l_fwd_d = ~err_q[EW-1] & (err_q != '0);
        end
        full_d  = big;
        rem_d   = prod[NW-1:QW];
        lo_d    = prod[QW-1:0];
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
        lo_d  = {lo_q[QW-2:0], ge};
        step_d = step_q + SW'(1);
        if (step_q == SW'(QW - 1)) begin
          // zero divisor and zero error: divider output is meaningless, power is 0
          if (full_q) begin
            pwr_now = PW'(dwqpc_pkg::PWM_FULL);
          end else if (divisor_q == '0) begin
            pwr_now = '0;
          end else begin
            pwr_now = PW'(lo_d);
          end
          if (wheel_q) begin
            r_pwr_d = pwr_now;
            state_d = ST_OUT;
          end else begin
            l_pwr_d = pwr_now;
            wheel_d = 1'b1;
            state_d = ST_TGT;
          end
        end
      end
      ST_OUT: begin
        // wait for the previous result word to drain
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_d     = {6'd0, r_pwr_q, r_fwd_q, l_pwr_q, l_fwd_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wheel_q   <= 1'b0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wheel_q   <= wheel_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    err_q   <= err_d;
    rem_q   <= rem_d;
    lo_q    <= lo_d;
    full_q  <= full_d;
    l_fwd_q <= l_fwd_d;
    r_fwd_q <= r_fwd_d;
    l_pwr_q <= l_pwr_d;
    r_pwr_q <= r_pwr_d;
    out_q   <= out_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
